// ===== src/rmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range min/max segment tree package
// Sizes, item kinds and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package rmm_pkg;

  localparam int MaxPositions  = 1024;
  localparam int ValueWidth    = 32;
  localparam int PosWidth      = 11;
  localparam int KindWidth     = 2;
  localparam int StoreDepth    = 2 * MaxPositions;
  localparam int AddrWidth     = $clog2(StoreDepth);
  localparam int StackDepth    = $clog2(MaxPositions);
  localparam int StackIdxWidth = $clog2(StackDepth);
  localparam int LevelWidth    = $clog2(StackDepth + 1);

  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic [PosWidth-1:0]          pos_t;
  typedef logic [AddrWidth-1:0]         addr_t;

  typedef enum logic [KindWidth-1:0] {
    KIND_WRITE = 2'd0,
    KIND_QMAX  = 2'd1,
    KIND_QMIN  = 2'd2,
    KIND_FILL  = 2'd3
  } kind_e;

  typedef struct packed {
    logic load;
    logic cfg_we;
    logic sweep_init;
    logic sweep_fill;
    logic sweep_step;
    logic wr_desc;
    logic wr_upd;
    logic q_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic  err;
    kind_e kind;
    logic  leaf;
    logic  level_zero;
    logic  q_last;
    logic  sweep_last;
    logic  out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/range_min_max_segment_tree.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range min/max segment tree
// Segment tree over positions 1..size_in_use; every node keeps the maximum
// and the minimum of its span in two node stores (2048 entries each, laid
// out in preorder). One item is processed at a time, and the next item is
// taken while a finished result still waits in the output register. A query
// walks the tree with one node step per cycle. A write descends one level
// per cycle and climbs back with a sibling read and a parent write per
// level. A fill item rewrites every node, one per cycle. After reset and
// after every size_in_use write the stores are cleared the same way, and no
// item is taken during the clear. A bad position or range returns error with
// answer zero.
// ----------------------------------------------------------------------------
module range_min_max_segment_tree import rmm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KindWidth-1:0] kind_i,
  input  logic [PosWidth-1:0]  position_i,
  input  value_t               value_i,
  input  logic [PosWidth-1:0]  range_low_i,
  input  logic [PosWidth-1:0]  range_high_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output value_t               answer_o,
  output logic                 error_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [PosWidth-1:0]  cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  rmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rmm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .cfg_data_i   (cfg_data_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .answer_o     (answer_o),
    .error_o      (error_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while previous item still in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> in_stall_o)
    else $error("item accepted during store clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.sweep_step, cmd.wr_desc, cmd.wr_upd, cmd.q_step}))
    else $error("store port claimed by two operations");

endmodule
`default_nettype wire

// ===== src/rmm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module rmm_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/rmm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range min/max segment tree datapath
// Tree walk registers, ancestor stack, max and min node stores, accumulator,
// size register and result register.
// ----------------------------------------------------------------------------
module rmm_datapath import rmm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  input  logic [KindWidth-1:0] kind_i,
  input  pos_t                 position_i,
  input  value_t               value_i,
  input  pos_t                 range_low_i,
  input  pos_t                 range_high_i,
  input  pos_t                 cfg_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output value_t               answer_o,
  output logic                 error_o
);

  pos_t   size_q, size_d;
  kind_e  kind_q;
  value_t value_q;
  logic   err_q, item_err;

  addr_t node_q, pnode_q;
  pos_t  lo_q, hi_q, ql_q, qr_q;
  pos_t  plo_q, phi_q, pql_q, pqr_q;
  logic  pend_q;

  logic [LevelWidth-1:0] level_q, lvl_m1;
  logic [StackIdxWidth-1:0] push_idx, top_idx;
  addr_t par_q [StackDepth];
  addr_t sib_q [StackDepth];

  value_t cur_max_q, cur_min_q, new_max, new_min;
  value_t acc_q, acc_d, acc_init;
  logic   rd_acc_q, rd_acc_d;

  addr_t  sweep_addr_q;
  value_t sweep_val_q;

  logic   out_valid_q, out_valid_d, error_q;
  value_t answer_q;

  logic [PosWidth:0] mid_sum;
  pos_t  mid, mid_p1, span;
  addr_t left_node, right_node, q_addr, rd_addr, wr_addr;
  logic  exact, leaf, go_left, go_right, q_read, split_both, want_max;

  logic   ram_we;
  value_t ram_wmax, ram_wmin, rd_max, rd_min;

  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = mid_sum[PosWidth:1];
  assign mid_p1     = mid + 1'b1;
  assign span       = mid - lo_q + 1'b1;
  assign left_node  = node_q + 1'b1;
  assign right_node = node_q + AddrWidth'({span, 1'b0});
  assign exact      = (lo_q == ql_q) && (hi_q == qr_q);
  assign leaf       = (lo_q == hi_q);
  assign go_left    = (qr_q <= mid);
  assign go_right   = (ql_q > mid);
  assign q_read     = exact || (!go_left && !go_right && ((qr_q == hi_q) || (ql_q == lo_q)));
  assign split_both = !exact && !go_left && !go_right && (qr_q != hi_q) && (ql_q != lo_q);
  assign want_max   = (kind_q == KIND_QMAX);

  assign lvl_m1   = level_q - 1'b1;
  assign push_idx = level_q[StackIdxWidth-1:0];
  assign top_idx  = lvl_m1[StackIdxWidth-1:0];

  always_comb begin
    if (exact) begin
      q_addr = node_q;
    end else if (qr_q == hi_q) begin
      q_addr = right_node;
    end else begin
      q_addr = left_node;
    end
  end

  always_comb begin
    if (cfg_data_i == '0) begin
      size_d = PosWidth'(1);
    end else if (cfg_data_i > PosWidth'(MaxPositions)) begin
      size_d = PosWidth'(MaxPositions);
    end else begin
      size_d = cfg_data_i;
    end
  end

  always_comb begin
    case (kind_e'(kind_i))
      KIND_WRITE: item_err = (position_i == '0) || (position_i > size_q);
      KIND_FILL:  item_err = 1'b0;
      default:    item_err = (range_low_i == '0) || (range_high_i > size_q) ||
                             (range_low_i > range_high_i);
    endcase
  end

  assign acc_init = (kind_e'(kind_i) == KIND_QMAX) ?
                    value_t'({1'b1, {(ValueWidth-1){1'b0}}}) :
                    value_t'({1'b0, {(ValueWidth-1){1'b1}}});

  assign new_max = (cur_max_q < rd_max) ? rd_max : cur_max_q;
  assign new_min = (rd_min < cur_min_q) ? rd_min : cur_min_q;

  always_comb begin
    if (want_max) begin
      acc_d = (acc_q < rd_max) ? rd_max : acc_q;
    end else begin
      acc_d = (rd_min < acc_q) ? rd_min : acc_q;
    end
  end

  assign rd_acc_d = cmd_i.q_step && q_read;
  assign rd_addr  = cmd_i.q_step ? q_addr : sib_q[top_idx];

  always_comb begin
    ram_we   = 1'b0;
    wr_addr  = par_q[top_idx];
    ram_wmax = new_max;
    ram_wmin = new_min;
    if (cmd_i.sweep_step) begin
      ram_we   = 1'b1;
      wr_addr  = sweep_addr_q;
      ram_wmax = sweep_val_q;
      ram_wmin = sweep_val_q;
    end else if (cmd_i.wr_desc && leaf) begin
      ram_we   = 1'b1;
      wr_addr  = node_q;
      ram_wmax = value_q;
      ram_wmin = value_q;
    end else if (cmd_i.wr_upd) begin
      ram_we   = 1'b1;
    end
  end

  rmm_ram #(.Width(ValueWidth), .Depth(StoreDepth)) u_max_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (ram_wmax),
    .raddr_i (rd_addr),
    .rdata_o (rd_max)
  );

  rmm_ram #(.Width(ValueWidth), .Depth(StoreDepth)) u_min_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (ram_wmin),
    .raddr_i (rd_addr),
    .rdata_o (rd_min)
  );

  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q       <= PosWidth'(MaxPositions);
      pend_q       <= 1'b0;
      level_q      <= '0;
      rd_acc_q     <= 1'b0;
      sweep_addr_q <= '0;
      sweep_val_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.cfg_we) begin
        size_q <= size_d;
      end
      rd_acc_q    <= rd_acc_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.sweep_init) begin
        sweep_addr_q <= '0;
        sweep_val_q  <= cmd_i.sweep_fill ? value_q : '0;
      end else if (cmd_i.sweep_step) begin
        sweep_addr_q <= sweep_addr_q + 1'b1;
      end
      if (cmd_i.load) begin
        pend_q <= 1'b0;
      end else if (cmd_i.q_step && exact) begin
        pend_q <= 1'b0;
      end else if (cmd_i.q_step && split_both) begin
        pend_q <= 1'b1;
      end
      if (cmd_i.load) begin
        level_q <= '0;
      end else if (cmd_i.wr_desc && !leaf) begin
        level_q <= level_q + 1'b1;
      end else if (cmd_i.wr_upd) begin
        level_q <= lvl_m1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_e'(kind_i);
      value_q   <= value_i;
      err_q     <= item_err;
      node_q    <= '0;
      lo_q      <= PosWidth'(1);
      hi_q      <= size_q;
      ql_q      <= (kind_e'(kind_i) == KIND_WRITE) ? position_i : range_low_i;
      qr_q      <= (kind_e'(kind_i) == KIND_WRITE) ? position_i : range_high_i;
      cur_max_q <= value_i;
      cur_min_q <= value_i;
      acc_q     <= acc_init;
    end else begin
      if (cmd_i.q_step) begin
        if (exact) begin
          if (pend_q) begin
            node_q <= pnode_q;
            lo_q   <= plo_q;
            hi_q   <= phi_q;
            ql_q   <= pql_q;
            qr_q   <= pqr_q;
          end
        end else if (go_left) begin
          node_q <= left_node;
          hi_q   <= mid;
        end else if (go_right) begin
          node_q <= right_node;
          lo_q   <= mid_p1;
        end else if (qr_q == hi_q) begin
          node_q <= left_node;
          hi_q   <= mid;
          qr_q   <= mid;
        end else if (ql_q == lo_q) begin
          node_q <= right_node;
          lo_q   <= mid_p1;
          ql_q   <= mid_p1;
        end else begin
          pnode_q <= right_node;
          plo_q   <= mid_p1;
          phi_q   <= hi_q;
          pql_q   <= mid_p1;
          pqr_q   <= qr_q;
          node_q  <= left_node;
          hi_q    <= mid;
          qr_q    <= mid;
        end
      end
      if (cmd_i.wr_desc && !leaf) begin
        par_q[push_idx] <= node_q;
        if (go_left) begin
          sib_q[push_idx] <= right_node;
          node_q          <= left_node;
          hi_q            <= mid;
        end else begin
          sib_q[push_idx] <= left_node;
          node_q          <= right_node;
          lo_q            <= mid_p1;
        end
      end
      if (cmd_i.wr_upd) begin
        cur_max_q <= new_max;
        cur_min_q <= new_min;
      end
      if (rd_acc_q) begin
        acc_q <= acc_d;
      end
    end
    if (cmd_i.out_load) begin
      answer_q <= (!err_q && (kind_q == KIND_QMAX || kind_q == KIND_QMIN)) ? acc_q : '0;
      error_q  <= err_q;
    end
  end

  assign stat_o.err        = err_q;
  assign stat_o.kind       = kind_q;
  assign stat_o.leaf       = leaf;
  assign stat_o.level_zero = (level_q == '0);
  assign stat_o.q_last     = exact && !pend_q;
  assign stat_o.sweep_last = (sweep_addr_q == AddrWidth'(StoreDepth - 1));
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;
  assign error_o     = error_q;

endmodule
`default_nettype wire

// ===== src/rmm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range min/max segment tree controller
// Sequences store sweeps, the write descent and ascent, and the query walk.
// ----------------------------------------------------------------------------
module rmm_ctrl import rmm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic  cfg_valid_i,
  output logic  cfg_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CHECK  = 9'b000000010,
    ST_SWEEP  = 9'b000000100,
    ST_WDESC  = 9'b000001000,
    ST_WREAD  = 9'b000010000,
    ST_WUPD   = 9'b000100000,
    ST_QSTEP  = 9'b001000000,
    ST_QDRAIN = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   emit_q, emit_d;

  assign cfg_ready_o = (state_q == ST_IDLE) || ((state_q == ST_SWEEP) && !emit_q);
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    emit_d  = emit_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          cmd_o.cfg_we     = 1'b1;
          cmd_o.sweep_init = 1'b1;
          emit_d           = 1'b0;
          state_d          = ST_SWEEP;
        end else if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.err) begin
          state_d = ST_DONE;
        end else begin
          case (stat_i.kind)
            KIND_WRITE: state_d = ST_WDESC;
            KIND_FILL: begin
              cmd_o.sweep_init = 1'b1;
              cmd_o.sweep_fill = 1'b1;
              emit_d           = 1'b1;
              state_d          = ST_SWEEP;
            end
            default: state_d = ST_QSTEP;
          endcase
        end
      end
      ST_SWEEP: begin
        if (cfg_valid_i && !emit_q) begin
          cmd_o.cfg_we     = 1'b1;
          cmd_o.sweep_init = 1'b1;
          emit_d           = 1'b0;
        end else begin
          cmd_o.sweep_step = 1'b1;
          if (stat_i.sweep_last) begin
            state_d = emit_q ? ST_DONE : ST_IDLE;
          end
        end
      end
      ST_WDESC: begin
        cmd_o.wr_desc = 1'b1;
        if (stat_i.leaf) begin
          state_d = ST_WREAD;
        end
      end
      ST_WREAD: begin
        state_d = stat_i.level_zero ? ST_DONE : ST_WUPD;
      end
      ST_WUPD: begin
        cmd_o.wr_upd = 1'b1;
        state_d      = ST_WREAD;
      end
      ST_QSTEP: begin
        cmd_o.q_step = 1'b1;
        if (stat_i.q_last) begin
          state_d = ST_QDRAIN;
        end
      end
      ST_QDRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

endmodule
`default_nettype wire

// ===== bench/range_min_max_segment_tree_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range min/max segment tree testbench
// Drives write, query and fill items and size_in_use writes into the tree.
// It keeps a flat copy of every position's value and predicts each answer
// and error flag from it. A checker compares every result with the oldest
// prediction. Directed edge cases come first, then random phases at
// several tree sizes under different patterns of sender idling and
// receiver stalls.
// ----------------------------------------------------------------------------
module range_min_max_segment_tree_test;
  import rmm_pkg::*;

  typedef struct {
    value_t answer;
    logic   error;
  } answer_t;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  localparam value_t MaxValue = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam value_t MinValue = {1'b1, {(ValueWidth-1){1'b0}}};
  localparam int unsigned ReportCap = 100;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [KindWidth-1:0] kind_i;
  pos_t                 position_i;
  value_t               value_i;
  pos_t                 range_low_i;
  pos_t                 range_high_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  value_t               answer_o;
  logic                 error_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  pos_t                 cfg_data_i;

  value_t      slot_value [1:MaxPositions];
  int unsigned tree_size;
  answer_t     expected_answers [$];
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  range_min_max_segment_tree i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .answer_o     (answer_o),
    .error_o      (error_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= ReportCap) begin
      $display("mismatch at result %0d: %s", result_count, msg);
    end
  endtask

  always @(posedge clk_i) begin : check_result
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected item answer %0d error %0b", answer_o, error_o));
      end else begin
        want = expected_answers.pop_front();
        if (answer_o !== want.answer) begin
          report_mismatch($sformatf("answer %0d, want %0d", answer_o, want.answer));
        end
        if (error_o !== want.error) begin
          report_mismatch($sformatf("error %0b, want %0b", error_o, want.error));
        end
      end
      result_count++;
    end
  end

  function automatic void clear_slots();
    foreach (slot_value[i]) slot_value[i] = '0;
  endfunction

  // Update the position copy and return the result the item must produce.
  function automatic answer_t apply_item(kind_e kind, pos_t pos, value_t val,
                                         pos_t lo, pos_t hi);
    answer_t res;
    res.answer = '0;
    res.error  = 1'b0;
    case (kind)
      KIND_WRITE: begin
        if (pos < 1 || pos > tree_size) res.error = 1'b1;
        else slot_value[pos] = val;
      end
      KIND_FILL: begin
        foreach (slot_value[i]) slot_value[i] = val;
      end
      default: begin
        if (lo < 1 || hi > tree_size || lo > hi) begin
          res.error = 1'b1;
        end else begin
          res.answer = slot_value[lo];
          for (int unsigned p = lo + 1; p <= hi; p++) begin
            if (kind == KIND_QMAX ? (slot_value[p] > res.answer)
                                  : (slot_value[p] < res.answer)) begin
              res.answer = slot_value[p];
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic pos_t any_pos();
    return pos_t'($urandom);
  endfunction

  function automatic value_t random_value();
    value_t v;
    case ($urandom_range(3))
      0: v = value_t'($urandom_range(16)) - 8;
      1: begin
        case ($urandom_range(3))
          0: v = MaxValue;
          1: v = MinValue;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = value_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 82; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 82; end
      IDLE_BOTH:     begin send_idle_pct = 22; recv_stall_pct = 22; end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic send_item(kind_e kind, pos_t pos, value_t val, pos_t lo, pos_t hi);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    kind_i       = kind;
    position_i   = pos;
    value_i      = val;
    range_low_i  = lo;
    range_high_i = hi;
    in_valid_i   = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_answers.insert(expected_answers.size(), apply_item(kind, pos, val, lo, hi));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_size(pos_t data);
    wait_idle();
    @(negedge clk_i);
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    tree_size = (data == 0) ? 1 : (data > MaxPositions) ? MaxPositions : data;
    clear_slots();
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_random_item();
    kind_e       kind;
    pos_t        pos;
    pos_t        lo;
    pos_t        hi;
    value_t      val;
    int unsigned pick;
    int unsigned top;
    kind = kind_e'($urandom_range(3));
    pos  = any_pos();
    lo   = any_pos();
    hi   = any_pos();
    val  = random_value();
    if ($urandom_range(99) < 88) begin
      pick = $urandom_range(99);
      pos  = pos_t'($urandom_range(tree_size, 1));
      lo   = pos_t'($urandom_range(tree_size, 1));
      top  = (lo + 7 < tree_size) ? lo + 7 : tree_size;
      hi   = $urandom_range(1) ? pos_t'($urandom_range(top, lo))
                               : pos_t'($urandom_range(tree_size, lo));
      if (pick < 42)      kind = KIND_WRITE;
      else if (pick < 70) kind = KIND_QMAX;
      else if (pick < 98) kind = KIND_QMIN;
      else                kind = KIND_FILL;
    end
    send_item(kind, pos, val, lo, hi);
  endtask

  task automatic test_reset_state();
    set_idling(IDLE_NONE);
    send_item(KIND_QMAX, any_pos(), random_value(), 1, 1024);
    send_item(KIND_QMIN, any_pos(), random_value(), 1, 1024);
  endtask

  task automatic test_edge_items();
    set_idling(IDLE_NONE);
    send_item(KIND_WRITE, 1, MaxValue, any_pos(), any_pos());
    send_item(KIND_WRITE, 1024, MinValue, any_pos(), any_pos());
    send_item(KIND_WRITE, 512, '1, any_pos(), any_pos());
    send_item(KIND_QMAX, any_pos(), random_value(), 1, 1024);
    send_item(KIND_QMIN, any_pos(), random_value(), 1, 1024);
    send_item(KIND_QMAX, any_pos(), random_value(), 1, 1);
    send_item(KIND_QMIN, any_pos(), random_value(), 1024, 1024);
    send_item(KIND_QMIN, any_pos(), random_value(), 2, 1023);
    send_item(KIND_QMAX, any_pos(), random_value(), 513, 1023);
    send_item(KIND_WRITE, 0, random_value(), any_pos(), any_pos());
    send_item(KIND_WRITE, 1025, random_value(), any_pos(), any_pos());
    send_item(KIND_WRITE, 2047, random_value(), any_pos(), any_pos());
    send_item(KIND_QMAX, any_pos(), random_value(), 0, 5);
    send_item(KIND_QMIN, any_pos(), random_value(), 1, 1025);
    send_item(KIND_QMAX, any_pos(), random_value(), 10, 9);
    send_item(KIND_QMIN, any_pos(), random_value(), 2047, 2047);
    send_item(KIND_FILL, any_pos(), MinValue, any_pos(), any_pos());
    send_item(KIND_QMAX, any_pos(), random_value(), 1, 1024);
    send_item(KIND_FILL, any_pos(), MaxValue, any_pos(), any_pos());
    send_item(KIND_WRITE, 700, 5, any_pos(), any_pos());
    send_item(KIND_QMIN, any_pos(), random_value(), 1, 1024);
    send_item(KIND_QMAX, any_pos(), random_value(), 700, 700);
  endtask

  task automatic test_size_register();
    set_idling(IDLE_NONE);
    write_size(0);
    send_item(KIND_WRITE, 1, 42, any_pos(), any_pos());
    send_item(KIND_QMAX, any_pos(), random_value(), 1, 1);
    send_item(KIND_WRITE, 2, random_value(), any_pos(), any_pos());
    write_size(1);
    send_item(KIND_QMIN, any_pos(), random_value(), 1, 1);
    write_size(2047);
    send_item(KIND_WRITE, 1024, -5, any_pos(), any_pos());
    send_item(KIND_QMIN, any_pos(), random_value(), 1, 1024);
  endtask

  task automatic test_random_traffic(pos_t size_data, idle_mode_e mode, int unsigned count);
    write_size(size_data);
    set_idling(mode);
    repeat (count) send_random_item();
    wait_idle();
    set_idling(IDLE_NONE);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_WRITE;
    position_i     = '0;
    value_i        = '0;
    range_low_i    = '0;
    range_high_i   = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    mismatch_count = 0;
    result_count   = 0;
    tree_size      = MaxPositions;
    clear_slots();
    set_idling(IDLE_NONE);
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_edge_items();
    test_size_register();
    test_random_traffic(2047, IDLE_NONE,     250);
    test_random_traffic(5,    IDLE_SENDER,   200);
    test_random_traffic(1,    IDLE_RECEIVER, 150);
    test_random_traffic(37,   IDLE_BOTH,     250);
    test_random_traffic(1024, IDLE_SENDER,   200);
    test_random_traffic(0,    IDLE_NONE,     100);
    test_random_traffic(200,  IDLE_RECEIVER, 250);
    test_random_traffic(16,   IDLE_BOTH,     250);
    test_random_traffic(1025, IDLE_BOTH,     200);

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (expected_answers.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
